// ===== rtl/core/lfbr_pkg.sv =====
// Shared types, constants and seed functions for the lagged Fibonacci generator.
// No dependencies; used by every module under rtl/core.
package lfbr_pkg;

   localparam int WORD_W         = 16;
   localparam int SEED_STEP      = 89;
   localparam int DEF_LONG_LAG   = 17;
   localparam int DEF_SHORT_LAG  = 5;

   typedef logic [WORD_W-1:0] word_type;

   // Seed of slot idx (1-based) before warm-up: 89*(idx-1)+1.
   function automatic word_type seed_word(input int idx);
      return WORD_W'((idx - 1) * SEED_STEP + 1);
   endfunction

   // Word written to slot long_lag by the warm-up step.
   function automatic word_type warm_sum(input int long_lag, input int short_lag);
      word_type short_word;
      short_word = (short_lag > long_lag) ? '0 : seed_word(short_lag);
      return WORD_W'(seed_word(long_lag) + short_word + word_type'(1));
   endfunction

   // Short index after the warm-up step.
   function automatic int warm_short(input int long_lag, input int short_lag);
      return (short_lag <= 1) ? long_lag : short_lag - 1;
   endfunction

   // Content of slot idx right after reset; slots past the long lag read 0.
   function automatic word_type reset_word(input int long_lag, input int short_lag,
                                           input int idx);
      word_type w;
      if (idx > long_lag) begin
         w = '0;
      end else if (idx == long_lag) begin
         w = warm_sum(long_lag, short_lag);
      end else begin
         w = seed_word(idx);
      end
      return w;
   endfunction

endpackage

// ===== rtl/core/lfbr_lag_ring.sv =====
// Lag word store with both descending indices and a registered read ahead.
// Depends on lfbr_pkg.
module lfbr_lag_ring #(
   parameter int LONG_LAG  = lfbr_pkg::DEF_LONG_LAG,
   parameter int SHORT_LAG = lfbr_pkg::DEF_SHORT_LAG
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  lfbr_pkg::word_type sum,
   output lfbr_pkg::word_type long_word,
   output lfbr_pkg::word_type short_word
);
   import lfbr_pkg::*;

   localparam int IDX_MAX = (LONG_LAG > SHORT_LAG) ? LONG_LAG : SHORT_LAG;
   localparam int IDX_W   = $clog2(IDX_MAX + 1);
   localparam int ADDR_W  = $clog2(LONG_LAG);
   localparam int LONG_START  = LONG_LAG - 1;
   localparam int SHORT_START = warm_short(LONG_LAG, SHORT_LAG);
   localparam word_type WARM       = warm_sum(LONG_LAG, SHORT_LAG);
   localparam word_type LONG_INIT  = reset_word(LONG_LAG, SHORT_LAG, LONG_START);
   localparam word_type SHORT_INIT = reset_word(LONG_LAG, SHORT_LAG, SHORT_START);

   word_type               mem [LONG_LAG];
   logic [LONG_LAG-1:0]    vld_ff, vld_in;
   logic [IDX_W-1:0]       long_idx_ff, long_idx_in;
   logic [IDX_W-1:0]       short_idx_ff, short_idx_in;
   logic [ADDR_W-1:0]      wr_addr, long_addr, short_addr;
   logic                   short_in_rng;
   logic                   long_hit, short_hit;
   word_type               long_mem_ff, short_mem_ff;
   logic                   long_use_ff, long_use_in, short_use_ff, short_use_in;
   word_type               long_alt_ff, long_alt_in, short_alt_ff, short_alt_in;

   function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] idx);
      return (idx <= IDX_W'(1)) ? IDX_W'(LONG_LAG) : IDX_W'(idx - IDX_W'(1));
   endfunction

   // Post-reset content of an in-range slot: seed, or the warm-up word at the top.
   function automatic word_type init_word(input logic [IDX_W-1:0] idx);
      word_type w;
      if (idx == IDX_W'(LONG_LAG)) begin
         w = WARM;
      end else begin
         w = WORD_W'(WORD_W'(idx) * WORD_W'(SEED_STEP) - WORD_W'(SEED_STEP - 1));
      end
      return w;
   endfunction

   always_comb begin
      long_idx_in  = adv ? step_idx(long_idx_ff)  : long_idx_ff;
      short_idx_in = adv ? step_idx(short_idx_ff) : short_idx_ff;

      wr_addr      = ADDR_W'(long_idx_ff - IDX_W'(1));
      long_addr    = ADDR_W'(long_idx_in - IDX_W'(1));
      short_in_rng = (short_idx_in <= IDX_W'(LONG_LAG));
      short_addr   = short_in_rng ? ADDR_W'(short_idx_in - IDX_W'(1)) : '0;

      vld_in = vld_ff;
      if (adv) begin
         vld_in[wr_addr] = 1'b1;
      end

      // Next reads bypass the word being written this cycle.
      long_hit  = (long_idx_in == long_idx_ff);
      short_hit = (short_idx_in == long_idx_ff);

      long_use_in  = !long_hit && vld_ff[long_addr];
      long_alt_in  = long_hit ? sum : init_word(long_idx_in);
      short_use_in = short_in_rng && !short_hit && vld_ff[short_addr];
      if (!short_in_rng) begin
         short_alt_in = '0;
      end else if (short_hit) begin
         short_alt_in = sum;
      end else begin
         short_alt_in = init_word(short_idx_in);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mem[wr_addr] <= sum;
         long_mem_ff  <= mem[long_addr];
         short_mem_ff <= mem[short_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         long_idx_ff  <= IDX_W'(LONG_START);
         short_idx_ff <= IDX_W'(SHORT_START);
         long_use_ff  <= 1'b0;
         short_use_ff <= 1'b0;
         long_alt_ff  <= LONG_INIT;
         short_alt_ff <= SHORT_INIT;
      end else if (adv) begin
         vld_ff       <= vld_in;
         long_idx_ff  <= long_idx_in;
         short_idx_ff <= short_idx_in;
         long_use_ff  <= long_use_in;
         short_use_ff <= short_use_in;
         long_alt_ff  <= long_alt_in;
         short_alt_ff <= short_alt_in;
      end
   end

   assign long_word  = long_use_ff  ? long_mem_ff  : long_alt_ff;
   assign short_word = short_use_ff ? short_mem_ff : short_alt_ff;

endmodule

// ===== rtl/core/lfbr_bound.sv =====
// Bounds the running sum to the bit length of the maximum, halving once if over.
// Depends on lfbr_pkg.
module lfbr_bound (
   input  lfbr_pkg::word_type limit,
   input  lfbr_pkg::word_type sum_word,
   output lfbr_pkg::word_type value
);
   import lfbr_pkg::*;

   word_type mask;
   word_type masked;

   always_comb begin
      mask = limit;
      for (int s = 1; s < WORD_W; s = s * 2) begin
         mask = mask | (mask >> s);
      end
      masked = sum_word & mask;
      value  = (masked > limit) ? (masked >> 1) : masked;
   end

endmodule

// ===== rtl/core/lagged_fibonacci_bounded_random.sv =====
// Additive lagged Fibonacci generator (default lags 17 and 5) returning a bounded value.
// Latency: result is shown the cycle after the request transfer; throughput one per cycle unless the consumer stalls.
// The lag words are read one item ahead into registers, so no read stalls the stream.
// Reset (synchronous): state equals the seeded table after one warm-up step; per-word
// valid bits stand in for the seed values, so there is no clearing pass.
// Depends on lfbr_pkg, lfbr_lag_ring, lfbr_bound.
module lagged_fibonacci_bounded_random #(
   parameter int LONG_LAG  = lfbr_pkg::DEF_LONG_LAG,
   parameter int SHORT_LAG = lfbr_pkg::DEF_SHORT_LAG
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  lfbr_pkg::word_type req_limit,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output lfbr_pkg::word_type rsp_value
);
   import lfbr_pkg::*;

   localparam word_type WARM = warm_sum(LONG_LAG, SHORT_LAG);

   logic     req_accept;
   word_type long_word, short_word;
   word_type lag_sum;
   word_type run_sum_ff, run_sum_in;
   word_type bounded;
   logic     rsp_valid_ff, rsp_valid_in;
   word_type rsp_value_ff, rsp_value_in;

   // Input is held only while a finished result waits and the consumer stalls.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // Lag store: advances both indices on every transfer, prefetches next words.
   lfbr_lag_ring #(
      .LONG_LAG  (LONG_LAG),
      .SHORT_LAG (SHORT_LAG)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .adv        (req_accept),
      .sum        (lag_sum),
      .long_word  (long_word),
      .short_word (short_word)
   );

   // New lag word and running sum, both mod 2^16.
   assign lag_sum    = WORD_W'(long_word + short_word + word_type'(1));
   assign run_sum_in = WORD_W'(run_sum_ff + lag_sum);

   lfbr_bound u_bound (
      .limit      (req_limit),
      .sum_word   (run_sum_in),
      .value      (bounded)
   );

   always_comb begin
      rsp_value_in = req_accept ? bounded : rsp_value_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff & rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_sum_ff   <= WARM;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            run_sum_ff <= run_sum_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   // Every request transfer yields a result in the next cycle.
   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("request transfer without result");

   // Generator state moves only on a request transfer.
   a_sum_holds_when_idle: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(run_sum_ff))
      else $error("running sum changed without transfer");

   // A fresh result never exceeds the maximum it was asked for.
   a_value_bounded: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (rsp_value <= $past(req_limit)))
      else $error("result above requested maximum");

endmodule
